>>> rtl/bfmd_pkg.sv
package bfmd_pkg;

  localparam int CH_W      = 8;
  localparam int NUM_CH    = 4;
  localparam int SUM_W     = 10;
  localparam int DIM_W     = 13;
  localparam int ROW_W     = 12;
  localparam int CFG_IDX_W = 1;

  localparam logic [DIM_W-1:0] HEIGHT_LIMIT = 13'd4096;
  localparam logic [DIM_W-1:0] DIM_RESET    = 13'd4096;

  // register indexes on the config channel
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

  typedef logic [CH_W-1:0]  chan_t;
  typedef logic [SUM_W-1:0] chan_sum_t;

  typedef struct packed {
    chan_t alpha;
    chan_t blue;
    chan_t green;
    chan_t red;
  } pixel_t;

  // horizontal pair sums, one field per channel
  typedef struct packed {
    chan_sum_t alpha;
    chan_sum_t blue;
    chan_sum_t green;
    chan_sum_t red;
  } pair_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } line_ctl_t;

endpackage

>>> rtl/bfmd_pixel_in_if.sv
interface bfmd_pixel_in_if;
  logic                 valid;
  logic                 ready;
  logic [bfmd_pkg::CH_W-1:0] in_red;
  logic [bfmd_pkg::CH_W-1:0] in_green;
  logic [bfmd_pkg::CH_W-1:0] in_blue;
  logic [bfmd_pkg::CH_W-1:0] in_alpha;

  modport source (output valid, in_red, in_green, in_blue, in_alpha, input ready);
  modport sink   (input valid, in_red, in_green, in_blue, in_alpha, output ready);
endinterface

>>> rtl/bfmd_pixel_out_if.sv
interface bfmd_pixel_out_if;
  logic                 valid;
  logic                 ready;
  logic [bfmd_pkg::CH_W-1:0] out_red;
  logic [bfmd_pkg::CH_W-1:0] out_green;
  logic [bfmd_pkg::CH_W-1:0] out_blue;
  logic [bfmd_pkg::CH_W-1:0] out_alpha;
  logic                 last_pixel;

  modport source (output valid, out_red, out_green, out_blue, out_alpha, last_pixel,
                  input ready);
  modport sink   (input valid, out_red, out_green, out_blue, out_alpha, last_pixel,
                  output ready);
endinterface

>>> rtl/bfmd_cfg_if.sv
interface bfmd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bfmd_pkg::CFG_IDX_W-1:0] index;
  logic [bfmd_pkg::DIM_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/box_filter_mip_downsampler_unit.sv
// A result passes through stage 1 and then the result register after the pixel that completes it is taken.
// Throughput: one source pixel per cycle; ready only drops while a result waits downstream.
// The per-pixel work runs between the input capture (line store read) and the result register.
// Reset (rst, sync, active high): counters and held pixel clear, both dims go to 4096.
// The line store has no reset or clearing pass; entries are always written before use.
module box_filter_mip_downsampler_unit #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic             clk,
  input  logic             rst,
  bfmd_pixel_in_if.sink    pix_in,
  bfmd_pixel_out_if.source pix_out,
  bfmd_cfg_if.sink         cfg
);
  import bfmd_pkg::*;

  // width of an effective width value (holds MAX_WIDTH itself)
  localparam int WW     = $clog2(MAX_WIDTH + 1);
  // column counter width (holds MAX_WIDTH-1)
  localparam int XW     = $clog2(MAX_WIDTH);
  localparam int LDEPTH = MAX_WIDTH / 2;
  localparam int LAW    = (LDEPTH > 1) ? $clog2(LDEPTH) : 1;

  // ---------------------------------------------------------------------------
  // Config registers. Writing either one restarts the frame.
  // ---------------------------------------------------------------------------
  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;
  logic             cfg_wr;

  assign cfg.ready = 1'b1;
  assign cfg_wr    = cfg.valid && cfg.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_RESET;
      image_height <= DIM_RESET;
    end else if (cfg_wr) begin
      unique case (cfg.index)
        CFG_IMAGE_WIDTH:  image_width  <= cfg.data;
        CFG_IMAGE_HEIGHT: image_height <= cfg.data;
        default: ;
      endcase
    end
  end

  // Effective dims: zero reads as one, oversize saturates.
  logic [WW-1:0]    eff_w;
  logic [DIM_W-1:0] eff_h;

  always_comb begin
    priority if (image_width == '0) begin
      eff_w = WW'(1);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(image_width);
    end
  end

  always_comb begin
    priority if (image_height == '0) begin
      eff_h = DIM_W'(1);
    end else if (image_height > HEIGHT_LIMIT) begin
      eff_h = HEIGHT_LIMIT;
    end else begin
      eff_h = image_height;
    end
  end

  logic             w_one;
  logic             h_one;
  logic [WW-1:0]    w_even;
  logic [DIM_W-1:0] h_even;
  logic [WW-1:0]    out_w_m1;

  assign w_one    = (eff_w == WW'(1));
  assign h_one    = (eff_h == DIM_W'(1));
  assign w_even   = {eff_w[WW-1:1], 1'b0};
  assign h_even   = {eff_h[DIM_W-1:1], 1'b0};
  assign out_w_m1 = w_one ? '0 : ((eff_w >> 1) - WW'(1));

  // ---------------------------------------------------------------------------
  // Raster position and the even-column pixel of the current pair.
  // ---------------------------------------------------------------------------
  logic [XW-1:0]    col_count;
  logic [ROW_W-1:0] row_count;
  logic [XW-1:0]    col_count_next;
  logic [ROW_W-1:0] row_count_next;
  pixel_t           left_pixel_hold;

  pixel_t pix;
  assign pix = '{alpha: pix_in.in_alpha, blue: pix_in.in_blue,
                 green: pix_in.in_green, red: pix_in.in_red};

  // Pipeline handshake: s1 holds an item whose line read is in flight,
  // the output register holds the finished result.
  logic s1_valid;
  logic out_valid;
  logic out_adv;
  logic s1_adv;
  logic in_acc;

  assign out_adv      = !out_valid || pix_out.ready;
  assign s1_adv       = s1_valid && out_adv;
  assign pix_in.ready = !s1_valid || out_adv;
  assign in_acc       = pix_in.valid && pix_in.ready;

  // ---------------------------------------------------------------------------
  // Per-pixel decode at the input transaction.
  // ---------------------------------------------------------------------------
  logic          x_in_span;
  logic          y_in_span;
  logic          have_pair;
  logic          hold_load;
  logic          emit;
  logic          last_flag;
  logic [LAW-1:0] ox;
  logic          x_wrap;
  logic          y_wrap;
  pair_t         pair;
  line_ctl_t     line_ctl;
  pixel_t        pair_lhs;

  function automatic pair_t pair_add(pixel_t p, pixel_t q);
    pair_t r;
    r.red   = SUM_W'(p.red)   + SUM_W'(q.red);
    r.green = SUM_W'(p.green) + SUM_W'(q.green);
    r.blue  = SUM_W'(p.blue)  + SUM_W'(q.blue);
    r.alpha = SUM_W'(p.alpha) + SUM_W'(q.alpha);
    return r;
  endfunction

  assign x_in_span = WW'(col_count) < w_even;
  assign y_in_span = DIM_W'(row_count) < h_even;
  assign have_pair = w_one || (x_in_span && col_count[0]);
  assign hold_load = !w_one && x_in_span && !col_count[0];
  // width one: the single column clamps into both taps
  assign pair_lhs  = w_one ? pix : left_pixel_hold;
  assign pair      = pair_add(pair_lhs, pix);
  assign ox        = LAW'(col_count >> 1);

  // even rows park pair sums; odd rows (or the only row) produce results
  assign emit      = have_pair && (h_one || (y_in_span && row_count[0]));
  assign last_flag = (h_one || (DIM_W'(row_count) == (h_even - DIM_W'(1))))
                     && (WW'(ox) == out_w_m1);

  assign line_ctl.wr_en = in_acc && have_pair && !h_one && y_in_span && !row_count[0];
  assign line_ctl.rd_en = in_acc && emit && !h_one;

  assign x_wrap = (WW'(col_count) + WW'(1)) >= eff_w;
  assign y_wrap = (DIM_W'(row_count) + DIM_W'(1)) >= eff_h;

  always_comb begin
    col_count_next = col_count + XW'(1);
    row_count_next = row_count;
    if (x_wrap) begin
      col_count_next = '0;
      row_count_next = y_wrap ? '0 : (row_count + ROW_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count       <= '0;
      row_count       <= '0;
      left_pixel_hold <= '0;
    end else begin
      if (cfg_wr) begin
        col_count <= '0;
        row_count <= '0;
      end else if (in_acc) begin
        col_count <= col_count_next;
        row_count <= row_count_next;
      end
      if (in_acc && hold_load) begin
        left_pixel_hold <= pix;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Line store of even-row pair sums.
  // ---------------------------------------------------------------------------
  pair_t line_rd;

  bfmd_line_mem #(
    .DEPTH (LDEPTH),
    .AW    (LAW)
  ) u_line_mem (
    .clk     (clk),
    .ctl     (line_ctl),
    .addr    (ox),
    .wr_data (pair),
    .rd_data (line_rd)
  );

  // ---------------------------------------------------------------------------
  // Stage 1: bottom pair waits here while the top pair is read.
  // ---------------------------------------------------------------------------
  logic  s1_load;
  pair_t s1_pair;
  logic  s1_last;
  logic  s1_h_one;

  assign s1_load = in_acc && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_pair  <= pair;
      s1_last  <= last_flag;
      s1_h_one <= h_one;
    end
  end

  // Rounded average: (top + bottom + 2) / 4 per channel.
  pair_t  top;
  pixel_t avg;

  function automatic chan_t round_avg(chan_sum_t a, chan_sum_t b);
    logic [SUM_W:0] s;
    s = (SUM_W+1)'(a) + (SUM_W+1)'(b) + (SUM_W+1)'(2);
    return s[CH_W+1:2];
  endfunction

  // height one: the single row clamps into both taps
  assign top       = s1_h_one ? s1_pair : line_rd;
  assign avg.red   = round_avg(top.red,   s1_pair.red);
  assign avg.green = round_avg(top.green, s1_pair.green);
  assign avg.blue  = round_avg(top.blue,  s1_pair.blue);
  assign avg.alpha = round_avg(top.alpha, s1_pair.alpha);

  // ---------------------------------------------------------------------------
  // Result register.
  // ---------------------------------------------------------------------------
  pixel_t out_pix;
  logic   out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (pix_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_pix  <= avg;
      out_last <= s1_last;
    end
  end

  assign pix_out.valid      = out_valid;
  assign pix_out.out_red    = out_pix.red;
  assign pix_out.out_green  = out_pix.green;
  assign pix_out.out_blue   = out_pix.blue;
  assign pix_out.out_alpha  = out_pix.alpha;
  assign pix_out.last_pixel = out_last;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_col_in_frame: assert property (@(posedge clk) disable iff (rst)
    WW'(col_count) < eff_w)
    else $error("column count outside the source width");

  a_row_in_frame: assert property (@(posedge clk) disable iff (rst)
    DIM_W'(row_count) < eff_h)
    else $error("row count outside the source height");

  a_line_one_op: assert property (@(posedge clk) disable iff (rst)
    !(line_ctl.wr_en && line_ctl.rd_en))
    else $error("line store read and written by the same pixel");

  a_s1_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !out_adv) |-> !s1_load)
    else $error("stage 1 overwritten while stalled");

  a_read_then_result: assert property (@(posedge clk) disable iff (rst)
    line_ctl.rd_en |=> s1_valid)
    else $error("line read without a pending result");

endmodule

>>> rtl/bfmd_line_mem.sv
module bfmd_line_mem #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic                 clk,
  input  bfmd_pkg::line_ctl_t  ctl,
  input  logic [AW-1:0]        addr,
  input  bfmd_pkg::pair_t      wr_data,
  output bfmd_pkg::pair_t      rd_data
);
  import bfmd_pkg::*;

  pair_t mem [DEPTH];

  // single port; contents undefined until written
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[addr];
    end
  end

endmodule
